### rtl/core/esc_pkg.sv
package esc_pkg;

    // queue between the front and the back
    localparam int QUEUE_DEPTH = 4;

    // widths fixed by the interface
    localparam int RAW_T_W   = 20;
    localparam int RAW_P_W   = 20;
    localparam int RAW_H_W   = 16;
    localparam int ITEM_W    = RAW_T_W + RAW_P_W + RAW_H_W;
    localparam int WORD_W    = 32;
    localparam int Q10_W     = 17;
    localparam int PCT_W     = 7;
    localparam int APB_DW    = 64;
    localparam int APB_AW    = 6;

    // register indexes
    localparam logic [2:0] REG_CAL_TEMP    = 3'd0;
    localparam logic [2:0] REG_CAL_PRESS_A = 3'd1;
    localparam logic [2:0] REG_CAL_PRESS_B = 3'd2;
    localparam logic [2:0] REG_CAL_PRESS_C = 3'd3;
    localparam logic [2:0] REG_CAL_HUM_A   = 3'd4;
    localparam logic [2:0] REG_CAL_HUM_B   = 3'd5;

    // compensation constants
    localparam logic [31:0] K_P_OFS     = 32'd64000;
    localparam logic [31:0] K_P_FULL    = 32'd1048576;
    localparam logic [31:0] K_P_SCALE   = 32'd3125;
    localparam logic [31:0] K_H_OFS     = 32'd76800;
    localparam logic [31:0] K_H_MAX     = 32'd419430400;
    localparam logic [31:0] K_H_BIAS    = 32'd2097152;
    localparam logic [31:0] K_RND_14    = 32'd16384;
    localparam logic [31:0] K_ONE_15    = 32'd32768;
    localparam logic [31:0] K_RND_13    = 32'd8192;
    localparam logic [31:0] K_RND_8     = 32'd128;

    typedef struct packed {
        logic [47:0] cal_temp;
        logic [63:0] cal_press_a;
        logic [63:0] cal_press_b;
        logic [15:0] cal_press_c;
        logic [55:0] cal_hum_a;
        logic [7:0]  cal_hum_b;
    } t_cal;

    typedef struct packed {
        logic [RAW_H_W-1:0] raw_hum;
        logic [RAW_P_W-1:0] raw_press;
        logic [RAW_T_W-1:0] raw_temp;
    } t_item;

    function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
        return a * b;
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx12(input logic [11:0] v);
        return {{20{v[11]}}, v};
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

endpackage

### rtl/core/esc_front.sv
module esc_front #(
    parameter int DEPTH = esc_pkg::QUEUE_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [esc_pkg::ITEM_W-1:0] i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output esc_pkg::t_item            o_item
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    esc_pkg::t_item    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              push, pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd];

    function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= nxt(r_wr);
            if (pop)  r_rd <= nxt(r_rd);
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= esc_pkg::t_item'(i_data);
    end
endmodule

### rtl/core/esc_div.sv
module esc_div #(
    parameter int WIDTH  = 32,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [WIDTH-1:0]  i_num,
    input  logic [WIDTH-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [WIDTH-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);
    // one quotient bit per stage, restoring
    logic              r_v    [WIDTH+1];
    logic [WIDTH-1:0]  r_rem  [WIDTH+1];
    logic [WIDTH-1:0]  r_num  [WIDTH+1];
    logic [WIDTH-1:0]  r_den  [WIDTH+1];
    logic [WIDTH-1:0]  r_quo  [WIDTH+1];
    logic [SIDE_W-1:0] r_side [WIDTH+1];

    always_comb begin
        r_v[0]    = i_valid;
        r_rem[0]  = '0;
        r_num[0]  = i_num;
        r_den[0]  = i_den;
        r_quo[0]  = '0;
        r_side[0] = i_side;
    end

    for (genvar s = 0; s < WIDTH; s++) begin : g_stage
        logic [WIDTH:0]   rsh;
        logic             ge;
        logic [WIDTH:0]   diff;
        assign rsh  = {r_rem[s], r_num[s][WIDTH-1]};
        assign diff = rsh - {1'b0, r_den[s]};
        assign ge   = (rsh >= {1'b0, r_den[s]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= ge ? diff[WIDTH-1:0] : rsh[WIDTH-1:0];
                r_num[s+1]  <= {r_num[s][WIDTH-2:0], 1'b0};
                r_den[s+1]  <= r_den[s];
                r_quo[s+1]  <= {r_quo[s][WIDTH-2:0], ge};
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_valid = r_v[WIDTH];
    assign o_quo   = r_quo[WIDTH];
    assign o_side  = r_side[WIDTH];
endmodule

### rtl/core/esc_back.sv
module esc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  esc_pkg::t_cal               i_cal,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  esc_pkg::t_item              i_item,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [31:0]                 o_temp_centi,
    output logic [31:0]                 o_press_pa,
    output logic                        o_press_ok,
    output logic [esc_pkg::Q10_W-1:0]   o_hum_q10,
    output logic [esc_pkg::PCT_W-1:0]   o_hum_percent
);
    localparam int SIDE_W = 32 + 32 + 32 + 2;

    logic en;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    // whole pipe moves together, stalls only when the output holds an item that is not taken
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    always_comb begin
        t1 = {16'd0, i_cal.cal_temp[15:0]};
        t2 = esc_pkg::sx16(i_cal.cal_temp[31:16]);
        t3 = esc_pkg::sx16(i_cal.cal_temp[47:32]);
        p1 = {16'd0, i_cal.cal_press_a[15:0]};
        p2 = esc_pkg::sx16(i_cal.cal_press_a[31:16]);
        p3 = esc_pkg::sx16(i_cal.cal_press_a[47:32]);
        p4 = esc_pkg::sx16(i_cal.cal_press_a[63:48]);
        p5 = esc_pkg::sx16(i_cal.cal_press_b[15:0]);
        p6 = esc_pkg::sx16(i_cal.cal_press_b[31:16]);
        p7 = esc_pkg::sx16(i_cal.cal_press_b[47:32]);
        p8 = esc_pkg::sx16(i_cal.cal_press_b[63:48]);
        p9 = esc_pkg::sx16(i_cal.cal_press_c);
        h1 = {24'd0, i_cal.cal_hum_a[7:0]};
        h2 = esc_pkg::sx16(i_cal.cal_hum_a[23:8]);
        h3 = {24'd0, i_cal.cal_hum_a[31:24]};
        h4 = esc_pkg::sx12(i_cal.cal_hum_a[43:32]);
        h5 = esc_pkg::sx12(i_cal.cal_hum_a[55:44]);
        h6 = esc_pkg::sx8(i_cal.cal_hum_b);
    end

    // valid chain
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10, r_v11;
    logic div_v;

    // stage payloads
    logic [31:0] r1_m1, r1_m2, r1_p, r1_h;
    logic [31:0] r2_a, r2_m3, r2_p, r2_h;
    logic [31:0] r3_tf, r3_p, r3_h;
    logic [31:0] r4_m5, r4_mq, r4_mp5, r4_mp2, r4_mh5, r4_mh6, r4_mh3, r4_p, r4_h;
    logic [31:0] r5_temp, r5_b6, r5_a3, r5_mp5, r5_mp2, r5_ha, r5_hb1, r5_p;
    logic [31:0] r6_temp, r6_b, r6_a1, r6_hm2, r6_ha, r6_p;
    logic [31:0] r7_temp, r7_div, r7_pn, r7_hv;
    logic [31:0] r8_temp, r8_num, r8_den, r8_hv, r8_hdd;
    logic        r8_big, r8_zero;
    logic [31:0] r9_temp, r9_p, r9_dd, r9_m8, r9_hx, r9_hv;
    logic        r9_zero;
    logic [31:0] r10_temp, r10_p, r10_m9, r10_b;
    logic [esc_pkg::Q10_W-1:0] r10_q10;
    logic        r10_zero;

    logic [31:0] div_quo;
    logic [SIDE_W-1:0] div_side;

    // combinational helpers per stage
    logic [31:0] s1_t, s1_d;
    logic [31:0] s4_pa, s4_q, s4_v;
    logic [31:0] s6_b, s6_a;
    logic [31:0] s8_d;
    logic [31:0] s9_q, s9_temp, s9_hv, s9_hdd;
    logic        s9_big, s9_zero;
    logic [31:0] s10_v;

    always_comb begin
        s1_t = {12'd0, i_item.raw_temp};
        s1_d = (s1_t >> 4) - t1;
        s4_pa = esc_pkg::asr(r3_tf, 1) - esc_pkg::K_P_OFS;
        s4_q  = esc_pkg::asr(s4_pa, 2);
        s4_v  = r3_tf - esc_pkg::K_H_OFS;
        s6_b  = r5_b6 + (r5_mp5 << 1);
        s6_a  = esc_pkg::asr(esc_pkg::asr(r5_a3, 3) + esc_pkg::asr(r5_mp2, 1), 18);
        s8_d  = esc_pkg::asr(r7_hv, 15);
        {s9_temp, s9_hv, s9_hdd, s9_big, s9_zero} = div_side;
        s9_q  = s9_big ? (div_quo << 1) : div_quo;
        s10_v = r9_hv - esc_pkg::asr(r9_hx, 4);
        if (s10_v[31])
            s10_v = '0;
        else if (s10_v > esc_pkg::K_H_MAX)
            s10_v = esc_pkg::K_H_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_v5 <= 1'b0; r_v6 <= 1'b0; r_v7 <= 1'b0; r_v8 <= 1'b0;
            r_v9 <= 1'b0; r_v10 <= 1'b0; r_v11 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
            r_v5 <= r_v4; r_v6 <= r_v5; r_v7 <= r_v6; r_v8 <= r_v7;
            r_v9 <= div_v; r_v10 <= r_v9; r_v11 <= r_v10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // temperature products
            r1_m1 <= esc_pkg::mul((s1_t >> 3) - (t1 << 1), t2);
            r1_m2 <= esc_pkg::mul(s1_d, s1_d);
            r1_p  <= {12'd0, i_item.raw_press};
            r1_h  <= {16'd0, i_item.raw_hum};

            r2_a  <= esc_pkg::asr(r1_m1, 11);
            r2_m3 <= esc_pkg::mul(esc_pkg::asr(r1_m2, 12), t3);
            r2_p  <= r1_p;
            r2_h  <= r1_h;

            r3_tf <= r2_a + esc_pkg::asr(r2_m3, 14);
            r3_p  <= r2_p;
            r3_h  <= r2_h;

            // first products off t_fine
            r4_m5  <= esc_pkg::mul(r3_tf, 32'd5);
            r4_mq  <= esc_pkg::mul(s4_q, s4_q);
            r4_mp5 <= esc_pkg::mul(s4_pa, p5);
            r4_mp2 <= esc_pkg::mul(p2, s4_pa);
            r4_mh5 <= esc_pkg::mul(h5, s4_v);
            r4_mh6 <= esc_pkg::mul(s4_v, h6);
            r4_mh3 <= esc_pkg::mul(s4_v, h3);
            r4_p   <= r3_p;
            r4_h   <= r3_h;

            r5_temp <= esc_pkg::asr(r4_m5 + esc_pkg::K_RND_8, 8);
            r5_b6   <= esc_pkg::mul(esc_pkg::asr(r4_mq, 11), p6);
            r5_a3   <= esc_pkg::mul(p3, esc_pkg::asr(r4_mq, 13));
            r5_mp5  <= r4_mp5;
            r5_mp2  <= r4_mp2;
            r5_ha   <= esc_pkg::asr((r4_h << 14) - (h4 << 20) - r4_mh5
                                    + esc_pkg::K_RND_14, 15);
            r5_hb1  <= esc_pkg::mul(esc_pkg::asr(r4_mh6, 10),
                                    esc_pkg::asr(r4_mh3, 11) + esc_pkg::K_ONE_15);
            r5_p    <= r4_p;

            r6_temp <= r5_temp;
            r6_b    <= esc_pkg::asr(s6_b, 2) + (p4 << 16);
            r6_a1   <= esc_pkg::mul(esc_pkg::K_ONE_15 + s6_a, p1);
            r6_hm2  <= esc_pkg::mul(esc_pkg::asr(r5_hb1, 10) + esc_pkg::K_H_BIAS, h2);
            r6_ha   <= r5_ha;
            r6_p    <= r5_p;

            // divisor and scaled dividend
            r7_temp <= r6_temp;
            r7_div  <= esc_pkg::asr(r6_a1, 15);
            r7_pn   <= esc_pkg::mul((esc_pkg::K_P_FULL - r6_p) - esc_pkg::asr(r6_b, 12),
                                    esc_pkg::K_P_SCALE);
            r7_hv   <= esc_pkg::mul(r6_ha,
                                    esc_pkg::asr(r6_hm2 + esc_pkg::K_RND_13, 14));

            r8_temp <= r7_temp;
            r8_big  <= r7_pn[31];
            r8_num  <= r7_pn[31] ? r7_pn : (r7_pn << 1);
            r8_den  <= r7_div;
            r8_zero <= (r7_div == '0);
            r8_hv   <= r7_hv;
            r8_hdd  <= esc_pkg::mul(s8_d, s8_d);

            // after the divider
            r9_temp <= s9_temp;
            r9_p    <= s9_q;
            r9_dd   <= esc_pkg::mul(s9_q >> 3, s9_q >> 3);
            r9_m8   <= esc_pkg::mul(s9_q >> 2, p8);
            r9_hx   <= esc_pkg::mul(esc_pkg::asr(s9_hdd, 7), h1);
            r9_hv   <= s9_hv;
            r9_zero <= s9_zero;

            r10_temp <= r9_temp;
            r10_p    <= r9_p;
            r10_m9   <= esc_pkg::mul(p9, r9_dd >> 13);
            r10_b    <= esc_pkg::asr(r9_m8, 13);
            r10_q10  <= s10_v[12 +: esc_pkg::Q10_W];
            r10_zero <= r9_zero;

            // output register
            o_temp_centi  <= r10_temp;
            o_press_pa    <= r10_zero ? '0 :
                             r10_p + esc_pkg::asr(esc_pkg::asr(r10_m9, 12) + r10_b + p7, 4);
            o_press_ok    <= !r10_zero;
            o_hum_q10     <= r10_q10;
            o_hum_percent <= r10_q10[10 +: esc_pkg::PCT_W];
        end
    end

    assign o_valid = r_v11;

    esc_div #(
        .WIDTH  (32),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v8),
        .i_num   (r8_num),
        .i_den   (r8_den),
        .i_side  ({r8_temp, r8_hv, r8_hdd, r8_big, r8_zero}),
        .o_valid (div_v),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );
endmodule

### rtl/core/env_sensor_compensation.sv
// Fixed-point compensation of one raw temperature/pressure/humidity sample per
// item, using factory calibration words written over the APB port (register i at
// byte address 8*i; write them while no item is in flight). Items enter a small
// queue and then a 43-stage pipeline: eight stages of temperature, t_fine and
// pressure/humidity products, a 32-stage restoring divider (one quotient bit per
// stage) for the pressure division, and two stages of final corrections plus
// the output register. One item is taken every cycle while the queue is not full; a stalled
// output holds the pipeline and fills the queue. A zero pressure divisor gives press_pa 0
// and press_ok 0 on tuser.
module env_sensor_compensation #(
    parameter int QUEUE_DEPTH = esc_pkg::QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // apb configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [esc_pkg::APB_AW-1:0]  paddr,
    input  logic [esc_pkg::APB_DW-1:0]  pwdata,
    output logic [esc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    // input items
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [55:0]                 i_s_tdata,  // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
    // result items
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [87:0]                 o_m_tdata,  // temp_centi[31:0], press_pa[63:32], hum_q10[80:64], hum_percent[87:81]
    output logic                        o_m_tuser   // press_ok
);
    esc_pkg::t_cal  r_cal;
    esc_pkg::t_item q_item;
    logic           q_valid, q_ready;
    logic [2:0]     reg_idx;
    logic [31:0]    temp_centi, press_pa;
    logic [esc_pkg::Q10_W-1:0] hum_q10;
    logic [esc_pkg::PCT_W-1:0] hum_percent;

    assign pready  = 1'b1;
    assign reg_idx = paddr[esc_pkg::APB_AW-1:3];

    // calibration registers, write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                esc_pkg::REG_CAL_TEMP:    r_cal.cal_temp    <= pwdata[47:0];
                esc_pkg::REG_CAL_PRESS_A: r_cal.cal_press_a <= pwdata;
                esc_pkg::REG_CAL_PRESS_B: r_cal.cal_press_b <= pwdata;
                esc_pkg::REG_CAL_PRESS_C: r_cal.cal_press_c <= pwdata[15:0];
                esc_pkg::REG_CAL_HUM_A:   r_cal.cal_hum_a   <= pwdata[55:0];
                esc_pkg::REG_CAL_HUM_B:   r_cal.cal_hum_b   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            esc_pkg::REG_CAL_TEMP:    prdata = {16'd0, r_cal.cal_temp};
            esc_pkg::REG_CAL_PRESS_A: prdata = r_cal.cal_press_a;
            esc_pkg::REG_CAL_PRESS_B: prdata = r_cal.cal_press_b;
            esc_pkg::REG_CAL_PRESS_C: prdata = {48'd0, r_cal.cal_press_c};
            esc_pkg::REG_CAL_HUM_A:   prdata = {8'd0, r_cal.cal_hum_a};
            esc_pkg::REG_CAL_HUM_B:   prdata = {56'd0, r_cal.cal_hum_b};
            default:                  prdata = '0;
        endcase
    end

    // front: takes items into the queue
    esc_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    // back: compensation pipeline with output register
    esc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cal         (r_cal),
        .i_valid       (q_valid),
        .o_ready       (q_ready),
        .i_item        (q_item),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_temp_centi  (temp_centi),
        .o_press_pa    (press_pa),
        .o_press_ok    (o_m_tuser),
        .o_hum_q10     (hum_q10),
        .o_hum_percent (hum_percent)
    );

    assign o_m_tdata = {hum_percent, hum_q10, press_pa, temp_centi};
endmodule

### bench/env_sensor_compensation_tb.sv
module env_sensor_compensation_tb;

    // one raw sample and one compensated reading
    typedef struct packed {
        logic [15:0] raw_hum;
        logic [19:0] raw_press;
        logic [19:0] raw_temp;
    } t_sample;

    typedef struct packed {
        logic [31:0] temp_centi;
        logic [31:0] press_pa;
        logic        press_ok;
        logic [16:0] hum_q10;
        logic [6:0]  hum_percent;
    } t_reading;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [esc_pkg::APB_AW-1:0] paddr = '0;
    logic [esc_pkg::APB_DW-1:0] pwdata = '0;
    logic [esc_pkg::APB_DW-1:0] prdata;
    logic pready;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [55:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [87:0] o_m_tdata;
    logic o_m_tuser;

    env_sensor_compensation DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    // calibration copy held by the bench
    logic [47:0] k_temp;
    logic [63:0] k_pa, k_pb;
    logic [15:0] k_pc;
    logic [55:0] k_ha;
    logic [7:0]  k_hb;

    t_sample  pending_samples[$];
    t_reading expected_readings[$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_cycles = 0;

    function automatic logic [31:0] sra(input logic [31:0] v, input int n);
        logic signed [31:0] s;
        s = v;
        return s >>> n;
    endfunction

    function automatic logic [31:0] sext(input logic [63:0] v, input int w);
        logic [63:0] m;
        m = (64'd1 << w) - 1;
        v = v & m;
        if (v[w-1]) v = v | ~m;
        return v[31:0];
    endfunction

    // integer compensation of one sample, all 32-bit wrapping
    function automatic t_reading compensate(input t_sample s);
        logic [31:0] at, ap, ah, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6, a, b, d, tf, p, v, q;
        t_reading r;
        at = {12'd0, s.raw_temp}; ap = {12'd0, s.raw_press}; ah = {16'd0, s.raw_hum};
        t1 = {16'd0, k_temp[15:0]}; t2 = sext(k_temp >> 16, 16); t3 = sext(k_temp >> 32, 16);
        p1 = {16'd0, k_pa[15:0]}; p2 = sext(k_pa >> 16, 16);
        p3 = sext(k_pa >> 32, 16); p4 = sext(k_pa >> 48, 16);
        p5 = sext(k_pb, 16); p6 = sext(k_pb >> 16, 16);
        p7 = sext(k_pb >> 32, 16); p8 = sext(k_pb >> 48, 16);
        p9 = sext({48'd0, k_pc}, 16);
        h1 = {24'd0, k_ha[7:0]}; h2 = sext({8'd0, k_ha} >> 8, 16); h3 = {24'd0, k_ha[31:24]};
        h4 = sext({8'd0, k_ha} >> 32, 12); h5 = sext({8'd0, k_ha} >> 44, 12);
        h6 = sext({56'd0, k_hb}, 8);
        // temperature gives t_fine
        a = sra(((at >> 3) - (t1 << 1)) * t2, 11);
        d = (at >> 4) - t1;
        b = sra(sra(d * d, 12) * t3, 14);
        tf = a + b;
        r.temp_centi = sra(tf * 32'd5 + 32'd128, 8);
        // pressure
        a = sra(tf, 1) - 32'd64000;
        b = sra(sra(a, 2) * sra(a, 2), 11) * p6;
        b = b + ((a * p5) << 1);
        b = sra(b, 2) + (p4 << 16);
        a = sra(sra(p3 * sra(sra(a, 2) * sra(a, 2), 13), 3) + sra(p2 * a, 1), 18);
        a = sra((32'd32768 + a) * p1, 15);
        if (a == 32'd0) begin
            // zero divisor
            p = '0;
            r.press_ok = 1'b0;
        end else begin
            r.press_ok = 1'b1;
            p = ((32'd1048576 - ap) - sra(b, 12)) * 32'd3125;
            if (p < 32'h80000000) p = (p << 1) / a;
            else p = (p / a) * 32'd2;
            d = p >> 3;
            a = sra(p9 * ((d * d) >> 13), 12);
            b = sra((p >> 2) * p8, 13);
            p = p + sra(a + b + p7, 4);
        end
        r.press_pa = p;
        // humidity, clamped before the final shift
        v = tf - 32'd76800;
        a = sra((ah << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
        b = sra(sra(v * h6, 10) * (sra(v * h3, 11) + 32'd32768), 10) + 32'd2097152;
        b = sra(b * h2 + 32'd8192, 14);
        v = a * b;
        d = sra(v, 15);
        v = v - sra(sra(d * d, 7) * h1, 4);
        if (v[31]) v = '0;
        if (v > 32'd419430400) v = 32'd419430400;
        q = v >> 12;
        r.hum_q10 = q[16:0];
        r.hum_percent = q[16:10];
        return r;
    endfunction

    // driver: offers the oldest pending sample
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_tvalid || o_s_tready) begin
                if (i_s_tvalid) expected_readings.push_back(compensate(i_s_tdata));
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_tdata <= pending_samples.pop_front();
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: compare each accepted reading with the oldest expectation
    always @(posedge i_clk) begin
        t_reading got, exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.temp_centi = o_m_tdata[31:0];
            got.press_pa = o_m_tdata[63:32];
            got.press_ok = o_m_tuser;
            got.hum_q10 = o_m_tdata[80:64];
            got.hum_percent = o_m_tdata[87:81];
            if (expected_readings.size() == 0) begin
                $display("%0t unexpected reading %h", $realtime, got);
                errors = errors + 1;
            end else begin
                exp_r = expected_readings.pop_front();
                if (got.temp_centi !== exp_r.temp_centi) begin
                    $display("%0t temp_centi exp %h got %h", $realtime,
                             exp_r.temp_centi, got.temp_centi);
                    errors = errors + 1;
                end
                if (got.press_pa !== exp_r.press_pa) begin
                    $display("%0t press_pa exp %h got %h", $realtime,
                             exp_r.press_pa, got.press_pa);
                    errors = errors + 1;
                end
                if (got.press_ok !== exp_r.press_ok) begin
                    $display("%0t press_ok exp %b got %b", $realtime,
                             exp_r.press_ok, got.press_ok);
                    errors = errors + 1;
                end
                if (got.hum_q10 !== exp_r.hum_q10) begin
                    $display("%0t hum_q10 exp %h got %h", $realtime,
                             exp_r.hum_q10, got.hum_q10);
                    errors = errors + 1;
                end
                if (got.hum_percent !== exp_r.hum_percent) begin
                    $display("%0t hum_percent exp %h got %h", $realtime,
                             exp_r.hum_percent, got.hum_percent);
                    errors = errors + 1;
                end
            end
        end
    end

    // apb write, setup then access
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= (esc_pkg::APB_AW)'(idx) << 3; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            esc_pkg::REG_CAL_TEMP:    k_temp = val[47:0];
            esc_pkg::REG_CAL_PRESS_A: k_pa = val;
            esc_pkg::REG_CAL_PRESS_B: k_pb = val;
            esc_pkg::REG_CAL_PRESS_C: k_pc = val[15:0];
            esc_pkg::REG_CAL_HUM_A:   k_ha = val[55:0];
            esc_pkg::REG_CAL_HUM_B:   k_hb = val[7:0];
            default: ;
        endcase
    endtask

    task automatic load_cal(input logic [47:0] t, input logic [63:0] pa, input logic [63:0] pb,
                            input logic [15:0] pc, input logic [55:0] ha, input logic [7:0] hb);
        write_reg(esc_pkg::REG_CAL_TEMP, {16'h0, t});
        write_reg(esc_pkg::REG_CAL_PRESS_A, pa);
        write_reg(esc_pkg::REG_CAL_PRESS_B, pb);
        write_reg(esc_pkg::REG_CAL_PRESS_C, {48'h0, pc});
        write_reg(esc_pkg::REG_CAL_HUM_A, {8'h0, ha});
        write_reg(esc_pkg::REG_CAL_HUM_B, {56'h0, hb});
    endtask

    // random calibration words, all fields at full width
    task automatic load_random_cal();
        load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                 16'($urandom), 56'({$urandom, $urandom}), 8'($urandom));
    endtask

    // wait until all samples are accepted and all readings drained
    task automatic drain();
        while (pending_samples.size() > 0 || i_s_tvalid || expected_readings.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample();
        t_sample s;
        s.raw_temp = 20'($urandom);
        s.raw_press = 20'($urandom);
        s.raw_hum = 16'($urandom);
        // mostly realistic readings, some fully random
        if ($urandom_range(3) != 0) begin
            s.raw_temp = 20'($urandom_range(560000, 400000));
            s.raw_press = 20'($urandom_range(450000, 250000));
            s.raw_hum = 16'($urandom_range(45000, 15000));
        end
        return s;
    endfunction

    task automatic random_phase(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) pending_samples.push_back(rand_sample());
        drain();
    endtask

    initial begin
        t_sample s;
        k_temp = '0; k_pa = '0; k_pb = '0; k_pc = '0; k_ha = '0; k_hb = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all-zero calibration gives a zero divisor
        s = '0; pending_samples.push_back(s);
        s = '1; pending_samples.push_back(s);
        drain();

        // typical factory calibration
        load_cal({16'd50, 16'd26435, 16'd27504},
                 {16'd3024, -16'sd2855, 16'd3024, 16'd36477} ^ 64'h0,
                 {16'd15500, -16'sd12000, -16'sd7, 16'd140},
                 16'd6000,
                 {12'd0, 12'd312, 8'd0, 16'd361, 8'd75} | {12'd50, 44'h0},
                 8'd30);
        // realistic data words rebuilt in field order, high field first
        load_cal({16'sd50, 16'sd26435, 16'd27504},
                 {16'sd2855 * 16'sd1, 16'sd3024, -16'sd10685, 16'd36477},
                 {-16'sd12000, 16'sd15500, -16'sd7, 16'sd140},
                 16'd6000,
                 {12'sd50, 12'sd312, 8'd0, 16'sd361, 8'd75},
                 8'd30);
        s = '0; pending_samples.push_back(s);
        s = '1; pending_samples.push_back(s);
        s.raw_temp = 20'd519888; s.raw_press = 20'd415148; s.raw_hum = 16'd30000;
        pending_samples.push_back(s);
        s.raw_temp = 20'hFFFFF; s.raw_press = 20'd0; s.raw_hum = 16'hFFFF;
        pending_samples.push_back(s);
        s.raw_temp = 20'd0; s.raw_press = 20'hFFFFF; s.raw_hum = 16'd0;
        pending_samples.push_back(s);
        repeat (10) pending_samples.push_back(rand_sample());
        drain();

        random_phase(200, 0, 0);
        random_phase(200, 52, 0);
        random_phase(200, 0, 52);
        random_phase(200, 34, 34);

        // extreme calibration words, all ones then random
        load_cal('1, '1, '1, '1, '1, '1);
        random_phase(100, 0, 0);
        load_random_cal();
        random_phase(150, 34, 34);

        // long receiver hold-off so the queue fills and stalls the input
        hold_cycles = 300;
        load_random_cal();
        random_phase(150, 0, 0);
        load_random_cal();
        random_phase(235, 52, 52);

        if (errors == 0) begin
            $display("env_sensor_compensation: match");
        end else begin
            $display("env_sensor_compensation: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("env_sensor_compensation: mismatch");
        $finish;
    end
endmodule
